[sv/lmsd_pkg.sv]
package lmsd_pkg;

  // Matrix geometry
  localparam int unsigned RowCount    = 16;
  localparam int unsigned ColumnCount = 16;

  localparam int unsigned ColBytes   = ColumnCount / 8;
  localparam int unsigned ColBits    = ColBytes * 8;
  localparam int unsigned ClrRowBits = (RowCount / 8) * 8;
  localparam int unsigned MaxBits    = (ColBits > ClrRowBits) ? ColBits : ClrRowBits;

  localparam int unsigned BitW  = $clog2(MaxBits + 1);
  localparam int unsigned RowW  = $clog2(RowCount + 1);
  localparam int unsigned IdxW  = RowW + 8;

  // Frame store
  localparam int unsigned StoreDepth = 32;
  localparam int unsigned AddrW      = 5;

  // Configuration port
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_DWELL_TICKS = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_SCAN_ENABLE = 8'd1;

  localparam logic [15:0] DwellReset = 16'd50;

  // Request codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // Request as held in the queue between front and back
  typedef struct packed {
    logic             func;
    logic [AddrW-1:0] byte_addr;
    logic [7:0]       byte_value;
  } req_t;

  // Pin levels driven to the matrix
  typedef struct packed {
    logic data;
    logic aclk;
    logic cclk;
    logic latch;
    logic oen;
  } pins_t;

  // One result
  typedef struct packed {
    pins_t pins;
    logic  frame_done;
  } rsp_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic valid;
    req_t req;
  } q_head_t;

endpackage

[sv/lmsd_intf.sv]
interface lmsd_in_if
  import lmsd_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [AddrW-1:0] byte_addr;
  logic [7:0]       byte_value;

  modport source (output valid, func, byte_addr, byte_value, input ready);
  modport sink   (input valid, func, byte_addr, byte_value, output ready);
endinterface

interface lmsd_out_if;
  logic valid;
  logic ready;
  logic serial_data;
  logic anode_clock;
  logic cathode_clock;
  logic latch_strobe;
  logic output_enable_n;
  logic frame_done;

  modport source (output valid, serial_data, anode_clock, cathode_clock, latch_strobe,
                  output_enable_n, frame_done, input ready);
  modport sink   (input valid, serial_data, anode_clock, cathode_clock, latch_strobe,
                  output_enable_n, frame_done, output ready);
endinterface

interface lmsd_cfg_if
  import lmsd_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/lmsd_front.sv]
module lmsd_front
  import lmsd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  req_t    in_req_i,
  output q_head_t head_o,
  input  logic    pop_i
);

  // Two-entry queue decoupling the input side from the sequencer
  req_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push;

  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.req   = slot_q[rd_ptr_q];

  // Entry payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_req_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      unique case ({push, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[sv/lmsd_back.sv]
module lmsd_back
  import lmsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  q_head_t     head_i,
  output logic        pop_o,
  input  logic [15:0] dwell_ticks_i,
  input  logic        scan_enable_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_rsp_o
);

  typedef enum logic [3:0] {
    PH_CLR_ROW_HI, PH_CLR_ROW_LO, PH_CLR_COL_HI, PH_CLR_COL_LO,
    PH_CLR_LAT_HI, PH_CLR_LAT_LO, PH_IDLE, PH_SEED_HI,
    PH_SEED_LO, PH_COL_HI, PH_COL_LO, PH_LAT_HI,
    PH_LAT_LO, PH_DWELL, PH_ROW_HI, PH_ROW_LO
  } phase_e;

  logic [7:0] store_q [StoreDepth];

  phase_e          phase_q, phase_d, cur;
  logic [BitW-1:0] bit_q, bit_d, bit_inc;
  logic [RowW-1:0] row_q, row_d, row_inc;
  logic [15:0]     dwell_q, dwell_d, limit;
  logic [16:0]     dwell_inc;
  pins_t           pins_q, pins_d;
  logic            done;
  logic            out_valid_q;
  rsp_t            rsp_q;
  logic            step;
  logic            scanning;
  logic [IdxW-1:0] idx_full;
  logic [7:0]      pix_byte;
  logic            pixel;

  // One request is carried out per cycle while the result slot is free
  assign step  = head_i.valid && (!out_valid_q || out_ready_i);
  assign pop_o = step;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // Column pixel lookup
  assign idx_full = IdxW'(row_q) * IdxW'(ColBytes) + IdxW'(bit_q >> 3);
  assign pix_byte = store_q[idx_full[AddrW-1:0]];
  assign pixel    = ~pix_byte[~bit_q[2:0]];

  assign bit_inc   = bit_q + BitW'(1);
  assign row_inc   = row_q + RowW'(1);
  assign dwell_inc = {1'b0, dwell_q} + 17'd1;
  assign limit     = (dwell_ticks_i == 16'd0) ? 16'd1 : dwell_ticks_i;
  assign scanning  = (phase_q >= PH_SEED_HI);

  // Next step of the pin sequencer
  always_comb begin
    phase_d = phase_q;
    bit_d   = bit_q;
    row_d   = row_q;
    dwell_d = dwell_q;
    pins_d  = pins_q;
    done    = 1'b0;
    cur     = phase_q;
    if (head_i.req.func == FUNC_TICK) begin
      if (scanning && !scan_enable_i) begin
        // abandon the frame
        phase_d = PH_IDLE;
        pins_d  = '{data: pins_q.data, aclk: 1'b0, cclk: 1'b0, latch: 1'b0, oen: 1'b1};
      end else begin
        if (phase_q == PH_IDLE) begin
          if (scan_enable_i) begin
            cur = PH_SEED_HI;
          end else begin
            pins_d = '{data: pins_q.data, aclk: 1'b0, cclk: 1'b0, latch: 1'b0, oen: 1'b1};
          end
        end
        unique case (cur)
          PH_CLR_ROW_HI: begin
            pins_d  = '{data: 1'b0, aclk: 1'b1, cclk: 1'b0, latch: 1'b0, oen: 1'b1};
            phase_d = PH_CLR_ROW_LO;
          end
          PH_CLR_ROW_LO: begin
            pins_d = '{data: pins_q.data, aclk: 1'b0, cclk: 1'b0, latch: 1'b0, oen: 1'b1};
            if (bit_inc >= BitW'(ClrRowBits)) begin
              bit_d   = '0;
              phase_d = PH_CLR_COL_HI;
            end else begin
              bit_d   = bit_inc;
              phase_d = PH_CLR_ROW_HI;
            end
          end
          PH_CLR_COL_HI: begin
            pins_d  = '{data: 1'b1, aclk: 1'b0, cclk: 1'b1, latch: 1'b0, oen: 1'b1};
            phase_d = PH_CLR_COL_LO;
          end
          PH_CLR_COL_LO: begin
            pins_d = '{data: pins_q.data, aclk: 1'b0, cclk: 1'b0, latch: 1'b0, oen: 1'b1};
            if (bit_inc >= BitW'(ColBits)) begin
              bit_d   = '0;
              phase_d = PH_CLR_LAT_HI;
            end else begin
              bit_d   = bit_inc;
              phase_d = PH_CLR_COL_HI;
            end
          end
          PH_CLR_LAT_HI: begin
            pins_d  = '{data: pins_q.data, aclk: 1'b0, cclk: 1'b0, latch: 1'b1, oen: 1'b1};
            phase_d = PH_CLR_LAT_LO;
          end
          PH_CLR_LAT_LO: begin
            pins_d  = '{data: pins_q.data, aclk: 1'b0, cclk: 1'b0, latch: 1'b0, oen: 1'b1};
            phase_d = PH_IDLE;
          end
          PH_IDLE: begin
            phase_d = PH_IDLE;
          end
          PH_SEED_HI: begin
            pins_d  = '{data: 1'b1, aclk: 1'b1, cclk: 1'b0, latch: 1'b0, oen: 1'b1};
            phase_d = PH_SEED_LO;
          end
          PH_SEED_LO: begin
            pins_d  = '{data: pins_q.data, aclk: 1'b0, cclk: 1'b0, latch: 1'b0, oen: 1'b1};
            row_d   = '0;
            bit_d   = '0;
            phase_d = PH_COL_HI;
          end
          PH_COL_HI: begin
            pins_d  = '{data: pixel, aclk: 1'b0, cclk: 1'b1, latch: 1'b0, oen: 1'b1};
            phase_d = PH_COL_LO;
          end
          PH_COL_LO: begin
            pins_d = '{data: pins_q.data, aclk: 1'b0, cclk: 1'b0, latch: 1'b0, oen: 1'b1};
            if (bit_inc >= BitW'(ColBits)) begin
              bit_d   = '0;
              phase_d = PH_LAT_HI;
            end else begin
              bit_d   = bit_inc;
              phase_d = PH_COL_HI;
            end
          end
          PH_LAT_HI: begin
            pins_d  = '{data: pins_q.data, aclk: 1'b0, cclk: 1'b0, latch: 1'b1, oen: 1'b1};
            phase_d = PH_LAT_LO;
          end
          PH_LAT_LO: begin
            pins_d  = '{data: pins_q.data, aclk: 1'b0, cclk: 1'b0, latch: 1'b0, oen: 1'b1};
            dwell_d = '0;
            phase_d = PH_DWELL;
          end
          PH_DWELL: begin
            pins_d = '{data: pins_q.data, aclk: 1'b0, cclk: 1'b0, latch: 1'b0, oen: 1'b0};
            if (dwell_inc >= {1'b0, limit}) begin
              dwell_d = '0;
              phase_d = PH_ROW_HI;
            end else begin
              dwell_d = dwell_inc[15:0];
            end
          end
          PH_ROW_HI: begin
            pins_d  = '{data: 1'b0, aclk: 1'b1, cclk: 1'b0, latch: 1'b0, oen: 1'b1};
            phase_d = PH_ROW_LO;
          end
          PH_ROW_LO: begin
            pins_d = '{data: pins_q.data, aclk: 1'b0, cclk: 1'b0, latch: 1'b0, oen: 1'b1};
            if (row_inc >= RowW'(RowCount)) begin
              row_d   = '0;
              done    = 1'b1;
              phase_d = PH_IDLE;
            end else begin
              row_d   = row_inc;
              phase_d = PH_COL_HI;
            end
          end
          default: phase_d = phase_q;
        endcase
      end
    end
  end

  // Frame store, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < StoreDepth; i++) begin
        store_q[i] <= 8'h00;
      end
    end else if (step && head_i.req.func == FUNC_WRITE) begin
      store_q[head_i.req.byte_addr] <= head_i.req.byte_value;
    end
  end

  // Sequencer state, pins and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_CLR_ROW_HI;
      bit_q       <= '0;
      row_q       <= '0;
      dwell_q     <= '0;
      pins_q      <= '{data: 1'b0, aclk: 1'b0, cclk: 1'b0, latch: 1'b0, oen: 1'b1};
      out_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      if (step) begin
        phase_q     <= phase_d;
        bit_q       <= bit_d;
        row_q       <= row_d;
        dwell_q     <= dwell_d;
        pins_q      <= pins_d;
        out_valid_q <= 1'b1;
        rsp_q       <= '{pins: pins_d, frame_done: done};
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[sv/led_matrix_scan_driver_top.sv]
// Channel  Role    Payload
// req_i    sink    func, byte_addr, byte_value
// rsp_o    source  serial_data, anode_clock, cathode_clock, latch_strobe,
//                  output_enable_n, frame_done
// cfg_i    sink    index, data (always ready)
//
// Every request (frame byte write or tick) yields one result; one request per cycle is
// sustained while results are taken, set by the single-step pin sequencer in the back end.
// An accepted request is registered in the queue slot, then in the result register.
// Reset clears the frame store at once (flip-flops) and starts the clear sequence.
// A stalled result holds its register; the queue keeps taking requests until full.
module led_matrix_scan_driver_top
  import lmsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  lmsd_in_if.sink    req_i,
  lmsd_out_if.source rsp_o,
  lmsd_cfg_if.sink   cfg_i
);

  logic [15:0] dwell_ticks_q;
  logic        scan_enable_q;
  req_t        in_req;
  q_head_t     head;
  logic        pop;
  rsp_t        rsp;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_ticks_q <= DwellReset;
      scan_enable_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_DWELL_TICKS: begin
          dwell_ticks_q <= cfg_i.data;
        end
        CFG_SCAN_ENABLE: begin
          scan_enable_q <= cfg_i.data[0];
        end
        default: ;
      endcase
    end
  end

  assign in_req = '{func: req_i.func, byte_addr: req_i.byte_addr,
                    byte_value: req_i.byte_value};

  lmsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .in_req_i   (in_req),
    .head_o     (head),
    .pop_i      (pop)
  );

  lmsd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .dwell_ticks_i (dwell_ticks_q),
    .scan_enable_i (scan_enable_q),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .out_rsp_o     (rsp)
  );

  assign rsp_o.serial_data     = rsp.pins.data;
  assign rsp_o.anode_clock     = rsp.pins.aclk;
  assign rsp_o.cathode_clock   = rsp.pins.cclk;
  assign rsp_o.latch_strobe    = rsp.pins.latch;
  assign rsp_o.output_enable_n = rsp.pins.oen;
  assign rsp_o.frame_done      = rsp.frame_done;

endmodule

[sv/lmsd_checker.sv]
module lmsd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic serial_data_i,
  input logic anode_clock_i,
  input logic cathode_clock_i,
  input logic latch_strobe_i,
  input logic output_enable_n_i,
  input logic frame_done_i
);

  // A stalled result stays offered with its payload unchanged
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({serial_data_i, anode_clock_i, cathode_clock_i, latch_strobe_i,
               output_enable_n_i, frame_done_i}))
    else $error("result dropped or changed while stalled");

  // Frame end leaves the grid blanked with all strobes low
  a_done_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_done_i |->
      output_enable_n_i && !anode_clock_i && !cathode_clock_i && !latch_strobe_i)
    else $error("frame end with pins active");

  // Never more than one of the strobes high
  a_one_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $onehot0({anode_clock_i, cathode_clock_i, latch_strobe_i}))
    else $error("two strobes high at once");

  // Rows are shown only with all strobes low
  a_oe_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !output_enable_n_i |->
      !anode_clock_i && !cathode_clock_i && !latch_strobe_i)
    else $error("shift or latch while output enabled");

endmodule

bind led_matrix_scan_driver_top lmsd_checker u_lmsd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (rsp_o.valid),
  .out_ready_i       (rsp_o.ready),
  .serial_data_i     (rsp_o.serial_data),
  .anode_clock_i     (rsp_o.anode_clock),
  .cathode_clock_i   (rsp_o.cathode_clock),
  .latch_strobe_i    (rsp_o.latch_strobe),
  .output_enable_n_i (rsp_o.output_enable_n),
  .frame_done_i      (rsp_o.frame_done)
);
